// ----- sv/sel_pkg.sv -----
// sel_pkg: shared types, codes and constants of the s-expression lexer
// no dependencies; compiled before the interfaces and modules
package sel_pkg;

    // width of the internal line counter and of the line field on the result channel
    localparam int LINE_BITS  = 24;
    localparam int LINE_OUT_W = 24;

    // lexer modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_SYMVAR = 2'd3;

    // result event codes
    localparam logic [1:0] EV_CHAR  = 2'd0;
    localparam logic [1:0] EV_DONE  = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;
    localparam logic [1:0] EV_END   = 2'd3;

    // token type codes
    localparam logic [2:0] TOK_NONE   = 3'd0;
    localparam logic [2:0] TOK_OPEN   = 3'd1;
    localparam logic [2:0] TOK_CLOSE  = 3'd2;
    localparam logic [2:0] TOK_STRING = 3'd3;
    localparam logic [2:0] TOK_INT    = 3'd4;
    localparam logic [2:0] TOK_FLOAT  = 3'd5;
    localparam logic [2:0] TOK_SYMBOL = 3'd6;
    localparam logic [2:0] TOK_VAR    = 3'd7;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5c;

    // lexer state kept between bytes
    typedef struct packed {
        logic [1:0]           mode;
        logic                 esc;
        logic                 is_int;
        logic                 is_var;
        logic [LINE_BITS-1:0] line_count;
    } sel_state_t;

    // one result item
    typedef struct packed {
        logic [1:0]            event_res;
        logic [2:0]            token_type;
        logic [7:0]            text_char;
        logic [LINE_OUT_W-1:0] line;
        logic                  last;
    } sel_res_t;

    function automatic sel_res_t mk_res(
        input logic [1:0]            ev,
        input logic [2:0]            tok,
        input logic [7:0]            c,
        input logic [LINE_OUT_W-1:0] ln
    );
        sel_res_t r;
        r.event_res  = ev;
        r.token_type = tok;
        r.text_char  = c;
        r.line       = ln;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

// ----- sv/sel_if.sv -----
// sel_if: valid/ready channel interfaces for the lexer text bytes and results
// depends on sel_pkg
interface sel_text_if;
    import sel_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface sel_result_if;
    import sel_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            event_res;
    logic [2:0]            token_type;
    logic [7:0]            text_char;
    logic [LINE_OUT_W-1:0] line;
    logic                  last;

    modport source (output valid, output event_res, output token_type, output text_char,
                    output line, output last, input ready);
    modport sink   (input valid, input event_res, input token_type, input text_char,
                    input line, input last, output ready);
endinterface

// ----- sv/sel_step.sv -----
// sel_step: next-state and result logic of the lexer for one byte
// depends on sel_pkg; gives up to two results per byte
module sel_step (
    input  sel_pkg::sel_state_t st,
    input  logic [7:0]          ch,
    output sel_pkg::sel_state_t nxt,
    output logic [1:0]          num_res,
    output sel_pkg::sel_res_t   res0,
    output sel_pkg::sel_res_t   res1
);
    import sel_pkg::*;

    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

    logic                             is_space;
    logic                             is_digit;
    logic                             is_paren;
    logic [2:0]                       done_tok;
    logic [2:0]                       paren_tok;
    logic [LINE_BITS-1:0]             line_new;
    logic [LINE_BITS+LINE_OUT_W-1:0]  line_ext;
    logic [LINE_OUT_W-1:0]            ln;

    // character classes
    assign is_space  = (ch == CH_SPACE) || (ch == CH_LF) || (ch == CH_CR) || (ch == CH_TAB);
    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_paren  = (ch == CH_LPAREN) || (ch == CH_RPAREN);
    assign paren_tok = (ch == CH_LPAREN) ? TOK_OPEN : TOK_CLOSE;

    // saturating line counter, reported after this byte
    assign line_new = ((ch == CH_LF) && (st.line_count != LINE_MAX))
                    ? st.line_count + LINE_ONE : st.line_count;
    assign line_ext = {{LINE_OUT_W{1'b0}}, line_new};
    assign ln       = line_ext[LINE_OUT_W-1:0];

    // type of the number or symbol that a delimiter completes
    always_comb
    begin
        if (st.mode == MODE_NUMBER)
        begin
            done_tok = st.is_int ? TOK_INT : TOK_FLOAT;
        end
        else
        begin
            done_tok = st.is_var ? TOK_VAR : TOK_SYMBOL;
        end
    end

    // mode transitions and results
    always_comb
    begin
        sel_res_t r0;
        sel_res_t r1;
        logic [1:0] k;

        nxt            = st;
        nxt.line_count = line_new;
        r0             = mk_res(EV_CHAR, TOK_NONE, ch, ln);
        r1             = mk_res(EV_END, TOK_NONE, CH_NUL, ln);
        k              = 2'd0;

        case (st.mode)
            MODE_START:
            begin
                if (ch == CH_NUL)
                begin
                    r0 = mk_res(EV_END, TOK_NONE, CH_NUL, ln);
                    k  = 2'd1;
                end
                else if (is_paren)
                begin
                    r0 = mk_res(EV_DONE, paren_tok, ch, ln);
                    k  = 2'd1;
                end
                else if (is_space)
                begin
                    k = 2'd0;
                end
                else if (ch == CH_QUOTE)
                begin
                    nxt.mode = MODE_STRING;
                    nxt.esc  = 1'b0;
                    k        = 2'd1;
                end
                else if ((ch == CH_MINUS) || is_digit)
                begin
                    nxt.mode   = MODE_NUMBER;
                    nxt.is_int = 1'b1;
                    k          = 2'd1;
                end
                else
                begin
                    nxt.mode = MODE_SYMVAR;
                    if (ch == CH_DOLLAR)
                    begin
                        nxt.is_var = 1'b1;
                    end
                    else
                    begin
                        nxt.is_var = 1'b0;
                        k          = 2'd1;
                    end
                end
            end

            MODE_STRING:
            begin
                if (ch == CH_NUL)
                begin
                    r0       = mk_res(EV_DONE, TOK_STRING, CH_NUL, ln);
                    k        = 2'd2;
                    nxt.mode = MODE_START;
                end
                else if ((ch == CH_QUOTE) && !st.esc)
                begin
                    r1       = mk_res(EV_DONE, TOK_STRING, CH_NUL, ln);
                    k        = 2'd2;
                    nxt.mode = MODE_START;
                end
                else
                begin
                    // backslash toggles so a doubled one escapes nothing
                    nxt.esc = (ch == CH_BSLASH) ? ~st.esc : 1'b0;
                    k       = 2'd1;
                end
            end

            MODE_NUMBER, MODE_SYMVAR:
            begin
                if (is_paren)
                begin
                    r0       = mk_res(EV_DONE, done_tok, CH_NUL, ln);
                    r1       = mk_res(EV_DONE, paren_tok, ch, ln);
                    k        = 2'd2;
                    nxt.mode = MODE_START;
                end
                else if (is_space)
                begin
                    r0       = mk_res(EV_DONE, done_tok, CH_NUL, ln);
                    k        = 2'd1;
                    nxt.mode = MODE_START;
                end
                else if (ch == CH_NUL)
                begin
                    r0       = mk_res(EV_DONE, done_tok, CH_NUL, ln);
                    k        = 2'd2;
                    nxt.mode = MODE_START;
                end
                else if (st.mode == MODE_SYMVAR)
                begin
                    k = 2'd1;
                end
                else if (ch == CH_DOT)
                begin
                    nxt.is_int = 1'b0;
                    k          = 2'd1;
                end
                else if (is_digit)
                begin
                    k = 2'd1;
                end
                else
                begin
                    r0       = mk_res(EV_ERROR, TOK_NONE, ch, ln);
                    k        = 2'd1;
                    nxt.mode = MODE_START;
                end
            end

            default:
            begin
                nxt.mode = MODE_START;
            end
        endcase

        // start mode always leaves the escape flag clear and the integer flag set
        if (nxt.mode == MODE_START)
        begin
            nxt.esc    = 1'b0;
            nxt.is_int = 1'b1;
        end

        r0.last = (k == 2'd1);
        r1.last = 1'b1;

        res0    = r0;
        res1    = r1;
        num_res = k;
    end

endmodule

// ----- sv/s_expression_lexer.sv -----
// s_expression_lexer: byte-serial s-expression tokenizer, top level
// a byte is held in the byte input register, then decoded into the result buffer, which drives the result channel
// throughput: one byte per cycle while the result channel takes each result; a byte that yields
//   two results holds the decode stage while the two-entry result buffer drains
// reset (rst_n low, asynchronous): lexer to start mode, line count 1, buffers empty
// depends on sel_pkg, sel_if and sel_step
module s_expression_lexer (
    input  logic                clk,
    input  logic                rst_n,
    sel_text_if.sink            text,
    sel_result_if.source        result
);
    import sel_pkg::*;

    localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

    logic        byte_vld_reg;
    logic [7:0]  byte_reg;
    sel_state_t  state_reg;
    sel_state_t  state_next;
    logic [1:0]  cnt_reg;
    sel_res_t    slot0_reg;
    sel_res_t    slot1_reg;
    logic [1:0]  num_res;
    sel_res_t    res0;
    sel_res_t    res1;
    logic        pop;
    logic        fire;

    // result buffer must be empty after this cycle before a byte is decoded
    assign pop        = result.valid && result.ready;
    assign fire       = byte_vld_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop));
    assign text.ready = !byte_vld_reg || fire;

    // byte input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            byte_vld_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            byte_reg <= text.ch;
        end
    end

    // decode logic
    sel_step u_step (
        .st      (state_reg),
        .ch      (byte_reg),
        .nxt     (state_next),
        .num_res (num_res),
        .res0    (res0),
        .res1    (res1)
    );

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= MODE_START;
            state_reg.esc        <= 1'b0;
            state_reg.is_int     <= 1'b1;
            state_reg.is_var     <= 1'b0;
            state_reg.line_count <= LINE_ONE;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // result buffer occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (fire)
        begin
            cnt_reg <= num_res;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // result buffer payload, head in slot 0
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign result.valid      = (cnt_reg != 2'd0);
    assign result.event_res  = slot0_reg.event_res;
    assign result.token_type = slot0_reg.token_type;
    assign result.text_char  = slot0_reg.text_char;
    assign result.line       = slot0_reg.line;
    assign result.last       = slot0_reg.last;

`ifndef ASSERT_OFF
    // buffer holds at most two results
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer over capacity");

    // a two-result byte shows a non-final result first
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (num_res == 2'd2) |=> result.valid && !result.last && (cnt_reg == 2'd2))
        else $error("two-result byte out of order");

    // line counter never leaves the valid range
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.line_count != '0)
        else $error("line counter reached zero");

    // the final result of a byte is the last one left in the buffer
    a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.last |-> cnt_reg == 2'd1)
        else $error("final result followed by another in buffer");
`endif

endmodule
